/* hdl/dce_pkg.sv */
// Package for the density clustering engine.
// Holds the word types, the register codes and the controller/datapath interface structs.
// No dependencies.
package dce_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 16;

    localparam int RADIUS_W        = 35;
    localparam int MINPTS_W        = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 35;
    localparam int PTR_W           = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 35'd1024;
    localparam logic [MINPTS_W-1:0] MINPTS_RESET = 7'd4;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQUARED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS     = 1'd1;

    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic               last_point;
    } in_word_t;

    typedef struct packed {
        logic [5:0] point_index;
        logic [5:0] cluster_id;
        logic       is_noise;
        logic       last_label;
    } out_word_t;

    typedef struct packed {
        logic             store_we;
        logic [PTR_W-1:0] ld_addr;
        logic             pair_go;
        logic [PTR_W-1:0] pair_a;
        logic [PTR_W-1:0] pair_b;
        logic             pair_end;
        logic [PTR_W-1:0] mark_addr;
        logic             mark_visit;
        logic             label_wr;
        logic [PTR_W-1:0] raw;
        logic             q_wr;
        logic [PTR_W-1:0] q_wr_addr;
        logic             q_rd;
        logic [PTR_W-1:0] q_rd_addr;
        logic             adj_rd;
        logic             dense_wr;
        logic             dense_big;
        logic [PTR_W-1:0] dense_id;
        logic             out_rd1;
        logic             out_rd2;
        logic             out_load;
        logic             out_last;
        logic             clear_all;
    } cmd_t;

    typedef struct packed {
        logic             visited;
        logic             core;
        logic             cand;
        logic [PTR_W-1:0] q_data;
        logic             adj_busy;
        logic             out_free;
    } sts_t;

endpackage

/* hdl/dce_dist.sv */
// Squared-distance pipeline: difference, squares, then compare against the radius.
// Three register stages; depends on dce_pkg.
module dce_dist
    import dce_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TAG_W      = 13
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [COORD_BITS-1:0]   ax,
    input  logic signed [COORD_BITS-1:0]   ay,
    input  logic signed [COORD_BITS-1:0]   bx,
    input  logic signed [COORD_BITS-1:0]   by,
    input  logic [TAG_W-1:0]               in_tag,
    input  logic [RADIUS_W-1:0]            radius,
    output logic                           out_valid,
    output logic                           out_hit,
    output logic [TAG_W-1:0]               out_tag,
    output logic                           busy
);

    localparam int D_W   = COORD_BITS + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int CMP_W = (SQ_W > RADIUS_W) ? SQ_W : RADIUS_W;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [TAG_W-1:0]      t1_reg, t2_reg, t3_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg;
    logic signed [SQ_W-1:0] sqx_reg, sqy_reg;
    logic                  hit_reg;
    logic [SQ_W-1:0]       sum;

    assign sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= in_tag;
        dx_reg  <= D_W'(ax) - D_W'(bx);
        dy_reg  <= D_W'(ay) - D_W'(by);
        t2_reg  <= t1_reg;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        t3_reg  <= t2_reg;
        hit_reg <= CMP_W'(sum) < CMP_W'(radius);
    end

    assign out_valid = v3_reg;
    assign out_hit   = hit_reg;
    assign out_tag   = t3_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

/* hdl/dce_datapath.sv */
// Datapath: configuration registers, point store, adjacency rows, marks, labels,
// seed queue, cluster table and the output register. Depends on dce_pkg and dce_dist.
module dce_datapath
    import dce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_word,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  out_stall,
    output logic                  out_valid,
    output out_word_t             out_word
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
    localparam int TAG_W = 2 * IDX_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

    logic [RADIUS_W-1:0] radius_reg;
    logic [MINPTS_W-1:0] minpts_reg;

    logic [2*COORD_BITS-1:0] store_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0]   adj_mem   [MAX_POINTS];
    logic [IDX_W-1:0]        label_mem [MAX_POINTS];
    logic [IDX_W-1:0]        queue_mem [MAX_POINTS];
    logic [IDX_W:0]          dense_mem [MAX_POINTS];

    logic signed [EXT_W-1:0]      ext_x, ext_y, sat_x, sat_y;
    logic [2*COORD_BITS-1:0]      rd_a_reg, rd_b_reg;
    logic                         s1_valid_reg;
    logic [TAG_W-1:0]             s1_tag_reg;
    logic                         d_valid, d_hit, d_busy;
    logic [TAG_W-1:0]             d_tag;
    logic [IDX_W-1:0]             d_a, d_b;
    logic                         d_last;
    logic [MAX_POINTS-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]             acc_reg, acc_next;
    logic [MAX_POINTS-1:0]        core_reg, visited_reg, assigned_reg;
    logic [MAX_POINTS-1:0]        row_q_reg;
    logic [IDX_W-1:0]             q_data_reg;
    logic [IDX_W-1:0]             lab_rd_reg;
    logic                         asg_rd_reg;
    logic [IDX_W:0]               dense_rd_reg;
    logic [IDX_W-1:0]             ma;
    logic                         noise;
    logic                         out_valid_reg;
    out_word_t                    out_word_reg;

    assign ma = cmd.mark_addr[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            minpts_reg <= MINPTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS_SQUARED: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_MIN_POINTS:     minpts_reg <= cfg_data[MINPTS_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        ext_x = EXT_W'(in_word.coord_x);
        ext_y = EXT_W'(in_word.coord_y);
        sat_x = (ext_x > SAT_HI) ? SAT_HI : ((ext_x < SAT_LO) ? SAT_LO : ext_x);
        sat_y = (ext_y > SAT_HI) ? SAT_HI : ((ext_y < SAT_LO) ? SAT_LO : ext_y);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
            store_mem[cmd.ld_addr[IDX_W-1:0]] <= {sat_y[COORD_BITS-1:0], sat_x[COORD_BITS-1:0]};
        rd_a_reg   <= store_mem[cmd.pair_a[IDX_W-1:0]];
        rd_b_reg   <= store_mem[cmd.pair_b[IDX_W-1:0]];
        s1_tag_reg <= {cmd.pair_end, cmd.pair_a[IDX_W-1:0], cmd.pair_b[IDX_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= cmd.pair_go;
    end

    dce_dist #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .ax        (rd_a_reg[COORD_BITS-1:0]),
        .ay        (rd_a_reg[2*COORD_BITS-1:COORD_BITS]),
        .bx        (rd_b_reg[COORD_BITS-1:0]),
        .by        (rd_b_reg[2*COORD_BITS-1:COORD_BITS]),
        .in_tag    (s1_tag_reg),
        .radius    (radius_reg),
        .out_valid (d_valid),
        .out_hit   (d_hit),
        .out_tag   (d_tag),
        .busy      (d_busy)
    );

    assign {d_last, d_a, d_b} = d_tag;

    always_comb
    begin
        row_next      = (d_b == '0) ? '0 : row_reg;
        row_next[d_b] = d_hit;
        acc_next      = ((d_b == '0) ? '0 : acc_reg) + CNT_W'(d_hit);
    end

    always_ff @(posedge clk)
    begin
        if (d_valid)
        begin
            row_reg <= row_next;
            acc_reg <= acc_next;
            if (d_last)
                adj_mem[d_a] <= row_next;
        end
        if (cmd.adj_rd)
            row_q_reg <= adj_mem[ma];
        if (cmd.label_wr)
            label_mem[ma] <= cmd.raw[IDX_W-1:0];
        if (cmd.q_wr)
            queue_mem[cmd.q_wr_addr[IDX_W-1:0]] <= ma;
        if (cmd.q_rd)
            q_data_reg <= queue_mem[cmd.q_rd_addr[IDX_W-1:0]];
        if (cmd.dense_wr)
            dense_mem[cmd.raw[IDX_W-1:0]] <= {cmd.dense_big, cmd.dense_id[IDX_W-1:0]};
        if (cmd.out_rd1)
        begin
            lab_rd_reg <= label_mem[ma];
            asg_rd_reg <= assigned_reg[ma];
        end
        if (cmd.out_rd2)
            dense_rd_reg <= dense_mem[lab_rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg     <= '0;
            visited_reg  <= '0;
            assigned_reg <= '0;
        end
        else
        begin
            if (d_valid && d_last)
                core_reg[d_a] <= MINPTS_W'(acc_next) >= minpts_reg;
            if (cmd.clear_all)
            begin
                visited_reg  <= '0;
                assigned_reg <= '0;
            end
            else
            begin
                if (cmd.mark_visit)
                    visited_reg[ma] <= 1'b1;
                if (cmd.label_wr)
                    assigned_reg[ma] <= 1'b1;
            end
        end
    end

    assign noise = !asg_rd_reg || !dense_rd_reg[IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg.point_index <= cmd.mark_addr;
            out_word_reg.cluster_id  <= noise ? 6'd0 : 6'(dense_rd_reg[IDX_W-1:0]);
            out_word_reg.is_noise    <= noise;
            out_word_reg.last_label  <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign sts.visited  = visited_reg[ma];
    assign sts.core     = core_reg[ma];
    assign sts.cand     = row_q_reg[ma] && !assigned_reg[ma];
    assign sts.q_data   = 6'(q_data_reg);
    assign sts.adj_busy = s1_valid_reg | d_busy;
    assign sts.out_free = !out_valid_reg || !out_stall;

endmodule

/* hdl/dce_ctrl.sv */
// Controller: sequences loading, the pair scan, seed and expansion steps and the label stream.
// Drives the datapath by command words; depends on dce_pkg.
module dce_ctrl
    import dce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_word,
    input  sts_t     sts,
    output cmd_t     cmd
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    typedef enum logic [3:0] {
        S_LOAD, S_ADJ, S_DRAIN, S_SEED, S_POP, S_QWAIT, S_CHECK,
        S_ROWWAIT, S_SCAN, S_CLOSE, S_OUT_A, S_OUT_B, S_OUT_C
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ld_reg, ld_next, n_reg, n_next;
    logic [CNT_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IDX_W-1:0] i_reg, i_next, p_reg, p_next, j_reg, j_next;
    logic [IDX_W-1:0] q_reg, q_next, raw_reg, raw_next, id_reg, id_next;
    logic [CNT_W-1:0] n_last;
    logic             i_last, j_last, p_last, accept;

    assign n_last = n_reg - CNT_W'(1);
    assign i_last = CNT_W'(i_reg) == n_last;
    assign j_last = CNT_W'(j_reg) == n_last;
    assign p_last = CNT_W'(p_reg) == n_last;
    assign in_stall = state_reg != S_LOAD;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ld_next    = ld_reg;
        n_next     = n_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        q_next     = q_reg;
        raw_next   = raw_reg;
        id_next    = id_reg;
        cmd        = '0;
        cmd.raw    = 6'(raw_reg);
        cmd.ld_addr = 6'(ld_reg);
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.store_we = ld_reg < MAX_CNT;
                    n_next = (ld_reg < MAX_CNT) ? ld_reg + CNT_W'(1) : ld_reg;
                    ld_next = n_next;
                    if (in_word.last_point)
                    begin
                        p_next = '0;
                        j_next = '0;
                        state_next = S_ADJ;
                    end
                end
            end
            S_ADJ:
            begin
                cmd.pair_go  = 1'b1;
                cmd.pair_a   = 6'(p_reg);
                cmd.pair_b   = 6'(j_reg);
                cmd.pair_end = j_last;
                if (j_last)
                begin
                    j_next = '0;
                    if (p_last)
                        state_next = S_DRAIN;
                    else
                        p_next = p_reg + IDX_W'(1);
                end
                else
                    j_next = j_reg + IDX_W'(1);
            end
            S_DRAIN:
            begin
                if (!sts.adj_busy)
                begin
                    i_next = '0;
                    raw_next = '0;
                    id_next = '0;
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.mark_addr = 6'(i_reg);
                if (!sts.visited)
                    cmd.mark_visit = 1'b1;
                if (!sts.visited && sts.core)
                begin
                    cmd.label_wr  = 1'b1;
                    cmd.q_wr      = 1'b1;
                    cmd.q_wr_addr = '0;
                    tail_next = CNT_W'(1);
                    head_next = '0;
                    state_next = S_POP;
                end
                else if (i_last)
                begin
                    i_next = '0;
                    state_next = S_OUT_A;
                end
                else
                    i_next = i_reg + IDX_W'(1);
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    cmd.q_rd      = 1'b1;
                    cmd.q_rd_addr = 6'(head_reg[IDX_W-1:0]);
                    head_next = head_reg + CNT_W'(1);
                    state_next = S_QWAIT;
                end
                else
                    state_next = S_CLOSE;
            end
            S_QWAIT:
            begin
                q_next = sts.q_data[IDX_W-1:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.mark_addr = 6'(q_reg);
                j_next = '0;
                if (q_reg == i_reg)
                begin
                    cmd.adj_rd = 1'b1;
                    state_next = S_ROWWAIT;
                end
                else if (sts.visited)
                    state_next = S_POP;
                else
                begin
                    cmd.mark_visit = 1'b1;
                    if (sts.core)
                    begin
                        cmd.adj_rd = 1'b1;
                        state_next = S_ROWWAIT;
                    end
                    else
                        state_next = S_POP;
                end
            end
            S_ROWWAIT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.mark_addr = 6'(j_reg);
                if (sts.cand && tail_reg < MAX_CNT)
                begin
                    cmd.label_wr  = 1'b1;
                    cmd.q_wr      = 1'b1;
                    cmd.q_wr_addr = 6'(tail_reg[IDX_W-1:0]);
                    tail_next = tail_reg + CNT_W'(1);
                end
                if (j_last)
                    state_next = S_POP;
                else
                    j_next = j_reg + IDX_W'(1);
            end
            S_CLOSE:
            begin
                cmd.dense_wr  = 1'b1;
                cmd.dense_big = tail_reg > CNT_W'(1);
                cmd.dense_id  = 6'(id_reg);
                if (tail_reg > CNT_W'(1))
                    id_next = id_reg + IDX_W'(1);
                raw_next = raw_reg + IDX_W'(1);
                if (i_last)
                begin
                    i_next = '0;
                    state_next = S_OUT_A;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                    state_next = S_SEED;
                end
            end
            S_OUT_A:
            begin
                cmd.mark_addr = 6'(i_reg);
                cmd.out_rd1 = 1'b1;
                state_next = S_OUT_B;
            end
            S_OUT_B:
            begin
                cmd.out_rd2 = 1'b1;
                state_next = S_OUT_C;
            end
            S_OUT_C:
            begin
                cmd.mark_addr = 6'(i_reg);
                cmd.out_last  = i_last;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (i_last)
                    begin
                        cmd.clear_all = 1'b1;
                        ld_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                        state_next = S_OUT_A;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ld_reg    <= '0;
            n_reg     <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            i_reg     <= '0;
            p_reg     <= '0;
            j_reg     <= '0;
            q_reg     <= '0;
            raw_reg   <= '0;
            id_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ld_reg    <= ld_next;
            n_reg     <= n_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            i_reg     <= i_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
            q_reg     <= q_next;
            raw_reg   <= raw_next;
            id_reg    <= id_next;
        end
    end

endmodule

/* hdl/density_clustering_engine.sv */
// Density clustering engine: top level joining the controller and the datapath.
// Depends on dce_pkg, dce_ctrl and dce_datapath.
//
// Points load one word per cycle while the engine is idle; the word marked last starts a run
// and the input stalls until the last label word has been loaded into the output register. A
// run over n points first fills the adjacency rows through the single distance pipeline, then
// runs seed and queue expansion, each step scanning one adjacency row one point per cycle, and
// finally streams each label through the label and cluster tables.
module density_clustering_engine
    import dce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    dce_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .sts      (sts),
        .cmd      (cmd)
    );

    dce_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

/* hdl/dce_checker.sv */
// Port-level checks for the density clustering engine, bound to the top level.
// Depends on dce_pkg.
module dce_checker
    import dce_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input in_word_t              in_word,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_word_t             out_word
);

    // A stalled output word stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // Accepting the last point of a data set closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.last_point |=> in_stall)
        else $error("input open after last point");

    // A noise label carries cluster number zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.is_noise |-> out_word.cluster_id == 6'd0)
        else $error("noise label with nonzero cluster");

    // While a label other than the last one is held, the input stays closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last_label |-> in_stall)
        else $error("input open during label stream");

endmodule

bind density_clustering_engine dce_checker u_chk (.*);

/* tb/sv/density_clustering_engine_test.sv */
// Self-checking testbench for density_clustering_engine: point sets are streamed in,
// and the label words are checked against an in-bench DBSCAN predictor.
// Depends on dce_pkg and the density_clustering_engine RTL.
`timescale 1ns / 1ps

module density_clustering_engine_test;
    import dce_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int UNLABELED = 127;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    in_word_t point_queue[$];
    out_word_t label_queue[$];

    logic [RADIUS_W-1:0] radius_sq;
    logic [MINPTS_W-1:0] core_min;
    logic signed [15:0] store_x[MAX_POINTS_DEF];
    logic signed [15:0] store_y[MAX_POINTS_DEF];
    int stored;
    int errors;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_hold;
    int idle_cycles;
    int items_sent;

    density_clustering_engine i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit is_near(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(store_x[a]) - longint'(store_x[b]);
        dy = longint'(store_y[a]) - longint'(store_y[b]);
        return (dx * dx + dy * dy) < longint'({29'd0, radius_sq});
    endfunction

    function automatic int degree(int p, int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++)
        begin
            if (is_near(p, i))
                c++;
        end
        return c;
    endfunction

    task automatic predict_labels(int n);
        int lab[MAX_POINTS_DEF];
        bit seen[MAX_POINTS_DEF];
        int seeds[MAX_POINTS_DEF];
        int members[MAX_POINTS_DEF];
        int dense[MAX_POINTS_DEF];
        int head;
        int tail;
        int raw;
        int q;
        int next_id;
        bit noise;
        out_word_t w;
        raw = 0;
        for (int i = 0; i < MAX_POINTS_DEF; i++)
        begin
            lab[i] = UNLABELED;
            seen[i] = 1'b0;
            members[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (seen[i])
                continue;
            seen[i] = 1'b1;
            if (degree(i, n) < int'(core_min))
                continue;
            lab[i] = raw;
            head = 0;
            tail = 1;
            seeds[0] = i;
            while (head < tail && head < MAX_POINTS_DEF)
            begin
                q = seeds[head] % MAX_POINTS_DEF;
                head++;
                if (q != i)
                begin
                    if (seen[q])
                        continue;
                    seen[q] = 1'b1;
                    if (degree(q, n) < int'(core_min))
                        continue;
                end
                for (int j = 0; j < n; j++)
                begin
                    if (lab[j] == UNLABELED && is_near(q, j) && tail < MAX_POINTS_DEF)
                    begin
                        lab[j] = raw;
                        seeds[tail] = j;
                        tail++;
                    end
                end
            end
            raw++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (lab[i] < MAX_POINTS_DEF)
                members[lab[i]]++;
        end
        next_id = 0;
        for (int k = 0; k < MAX_POINTS_DEF; k++)
        begin
            dense[k] = next_id;
            if (members[k] > 1)
                next_id++;
        end
        for (int i = 0; i < n; i++)
        begin
            noise = !(lab[i] < MAX_POINTS_DEF && members[lab[i] % MAX_POINTS_DEF] > 1);
            w.point_index = i[5:0];
            w.cluster_id = noise ? 6'd0 : dense[lab[i]][5:0];
            w.is_noise = noise;
            w.last_label = (i + 1 == n);
            label_queue = {label_queue, w};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (stored < MAX_POINTS_DEF)
                begin
                    store_x[stored] = in_word.coord_x;
                    store_y[stored] = in_word.coord_y;
                    stored++;
                end
                if (in_word.last_point)
                begin
                    predict_labels(stored);
                    stored = 0;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    in_word <= point_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_hold <= 0;
        end
        else
        begin
            if (stall_hold == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_hold <= $urandom_range(10, 80);
            end
            else
                stall_hold <= stall_hold - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 1);
                2: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= (stall_hold % 8) < 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (label_queue.size() == 0)
            begin
                $display("%t: unexpected label word, expected none, got %h", $realtime,
                         out_word);
                errors++;
            end
            else if (out_word !== label_queue[0])
            begin
                $display("%t: label mismatch, expected %h, got %h", $realtime,
                         label_queue[0], out_word);
                errors++;
                void'(label_queue.pop_front());
            end
            else
                void'(label_queue.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("density_clustering_engine regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_RADIUS_SQUARED)
            radius_sq = value[RADIUS_W-1:0];
        else
            core_min = value[MINPTS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_point(int x, int y, bit last);
        in_word_t w;
        w.coord_x = x[15:0];
        w.coord_y = y[15:0];
        w.last_point = last;
        point_queue = {point_queue, w};
        items_sent++;
    endtask

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic add_set(int n);
        int cx;
        int cy;
        int spread;
        int style;
        int px;
        int py;
        style = $urandom_range(0, 5);
        cx = $signed($urandom_range(0, 65535)) - 32768;
        cy = $signed($urandom_range(0, 65535)) - 32768;
        spread = $urandom_range(2, 60);
        for (int i = 0; i < n; i++)
        begin
            if (style == 0)
            begin
                px = int'($urandom_range(0, 65535)) - 32768;
                py = int'($urandom_range(0, 65535)) - 32768;
            end
            else if (style == 1 && i > 0 && $urandom_range(0, 1) == 1)
            begin
                px = px;
                py = py;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    cx = int'($urandom_range(0, 65535)) - 32768;
                    cy = int'($urandom_range(0, 65535)) - 32768;
                end
                px = clamp16(cx + int'($urandom_range(0, 2 * spread)) - spread);
                py = clamp16(cy + int'($urandom_range(0, 2 * spread)) - spread);
            end
            add_point(px, py, i == n - 1);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (point_queue.size() > 0 || in_valid || label_queue.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] radii[10];
        logic [MINPTS_W-1:0] mins[10];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        radius_sq = RADIUS_RESET;
        core_min = MINPTS_RESET;
        stored = 0;
        errors = 0;
        idle_cycles = 0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_point(0, 0, 0);
        add_point(10, 0, 0);
        add_point(0, 10, 0);
        add_point(10, 10, 0);
        add_point(5, 5, 0);
        add_point(40, 0, 0);
        add_point(-32768, -32768, 0);
        add_point(32767, 32767, 0);
        add_point(-32768, 32767, 0);
        add_point(32767, -32768, 1);
        add_point(123, -456, 1);
        drain();

        write_reg(REG_MIN_POINTS, 35'd1);
        add_point(7, 7, 0);
        add_point(7, 7, 0);
        add_point(900, 900, 1);
        drain();

        radii = '{35'd0, 35'd17179869184, 35'h7FFFFFFFF, 35'd400, 35'd2500,
                  35'd1, 35'd900, 35'd2000, 35'd5000, 35'd1024};
        mins = '{7'd1, 7'd64, 7'd0, 7'd0, 7'd3, 7'd1, 7'd127, 7'd2, 7'd3, 7'd4};
        for (int k = 0; k < 10; k++)
        begin
            write_reg(REG_RADIUS_SQUARED, radii[k]);
            write_reg(REG_MIN_POINTS, {28'd0, mins[k]});
            for (int s = 0; s < 2; s++)
                add_set($urandom_range(1, 10));
            if (k == 8)
                add_set(MAX_POINTS_DEF + 2);
            drain();
        end
        while (items_sent < 180)
        begin
            write_reg(REG_RADIUS_SQUARED, CFG_DATA_W'($urandom_range(0, 6000)));
            write_reg(REG_MIN_POINTS, CFG_DATA_W'($urandom_range(1, 6)));
            add_set($urandom_range(2, 12));
            add_set($urandom_range(1, 12));
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("density_clustering_engine regression: pass");
        else
            $display("density_clustering_engine regression: fail");
        $finish;
    end

endmodule

/* density_clustering_engine.f */
hdl/dce_pkg.sv
hdl/dce_dist.sv
hdl/dce_datapath.sv
hdl/dce_ctrl.sv
hdl/density_clustering_engine.sv
hdl/dce_checker.sv
tb/sv/density_clustering_engine_test.sv
